// ===== sv/cdq_pkg.sv =====
`default_nettype none
package cdq_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int WORD_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_SEARCH     = 3'd4,
    REQ_REWIND     = 3'd5,
    REQ_STEP       = 3'd6
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SEARCH
  } state_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] data_out;
    logic [1:0]  status;
    logic [4:0]  item_count;
  } out_item_t;

endpackage
`default_nettype wire

// ===== sv/circular_deque_with_cursor.sv =====
// Ring-buffer deque of CAPACITY words with a read cursor.
// Input channel in_valid/in_stall/in_data carries one request per beat:
// push front/back, pop front/back, search, rewind cursor, step cursor.
// Output channel out_valid/out_stall/out_data returns exactly one beat per
// request: data word, status and the entry count after the request.
// Timing: a request is taken while the sequencer is idle and executed in
// the next cycle. Pushes and refused requests post their result there.
// Pops, rewind and step go through the registered read port of the entry
// memory, which adds a read state before the result. A search compares one
// stored entry per cycle on the single read port and the shared cursor
// advance unit, and compares at most as many entries as the deque holds.
// in_stall is high whenever a request is in progress. The result sits in
// an output register; a new request may be taken while it waits, but the
// sequencer holds in its execute cycle until the register is free.
// Reset (synchronous, rst_n low) empties the deque, puts front, back and
// cursor at zero and drops out_valid. Memory contents are not cleared;
// only written entries are ever read.
`default_nettype none
module circular_deque_with_cursor #(
  parameter int CAPACITY   = cdq_pkg::CAPACITY_DEF,
  parameter int WORD_WIDTH = cdq_pkg::WORD_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire cdq_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output cdq_pkg::out_item_t     out_data
);
  import cdq_pkg::*;

  localparam int IW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
  localparam logic [IW:0]   CAP_W    = (IW + 1)'(CAPACITY);
  localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

  logic [WORD_WIDTH-1:0] mem [CAPACITY];

  state_t          state_r, state_nxt;
  req_t            req_r;
  logic [31:0]     val_r;
  logic [IW-1:0]   front_r, front_nxt;
  logic [IW-1:0]   back_r, back_nxt;
  logic [IW-1:0]   cursor_r, cursor_nxt;
  logic [IW-1:0]   srch_r, srch_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;
  logic [WORD_WIDTH-1:0] rd_data_r;

  logic            accept, out_free, load_out, wr_en, empty, full;
  logic [IW-1:0]   wr_addr, rd_addr;
  logic [IW-1:0]   front_prev, front_next, back_prev, back_next;
  logic [IW-1:0]   adv_in, adv_out, adv_next;
  logic [IW:0]     adv_sum, adv_off;
  logic [63:0]     val_ext, vw_ext, rd_ext;
  logic [WORD_WIDTH-1:0] val_w;
  logic [31:0]     val_echo, rd_word, cnt_ext;
  logic [31:0]     res_data;
  status_t         res_status;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign empty    = (count_r == '0);
  assign full     = (count_r == FULL_CNT);

  assign val_ext  = 64'(val_r);
  assign val_w    = val_ext[WORD_WIDTH-1:0];
  assign vw_ext   = 64'(val_w);
  assign val_echo = vw_ext[31:0];
  assign rd_ext   = 64'(rd_data_r);
  assign rd_word  = rd_ext[31:0];
  assign cnt_ext  = 32'(count_nxt);

  assign front_prev = (front_r == '0) ? LAST_IDX : front_r - 1'b1;
  assign front_next = (front_r == LAST_IDX) ? '0 : front_r + 1'b1;
  assign back_prev  = (back_r == '0) ? LAST_IDX : back_r - 1'b1;
  assign back_next  = (back_r == LAST_IDX) ? '0 : back_r + 1'b1;

  // shared cursor advance: next stored entry, wrapping to the front one
  assign adv_sum  = {1'b0, adv_in} + CAP_W - {1'b0, front_r};
  assign adv_off  = (adv_sum >= CAP_W) ? adv_sum - CAP_W : adv_sum;
  assign adv_next = (adv_in == LAST_IDX) ? '0 : adv_in + 1'b1;
  assign adv_out  = (adv_off + 1'b1 >= (IW + 1)'(count_r)) ? front_r : adv_next;

  always_comb begin
    state_nxt  = state_r;
    front_nxt  = front_r;
    back_nxt   = back_r;
    cursor_nxt = cursor_r;
    srch_nxt   = srch_r;
    count_nxt  = count_r;
    load_out   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = back_r;
    rd_addr    = front_r;
    adv_in     = cursor_r;
    res_data   = '0;
    res_status = ST_OK;

    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          case (req_r)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              state_nxt = S_IDLE;
              load_out  = 1'b1;
              if (full) begin
                res_status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
                res_data  = val_echo;
                if (req_r == REQ_PUSH_FRONT) begin
                  wr_addr   = front_prev;
                  front_nxt = front_prev;
                end else begin
                  wr_addr  = back_r;
                  back_nxt = back_next;
                end
              end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
              if (empty) begin
                state_nxt  = S_IDLE;
                load_out   = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                state_nxt = S_READ;
                count_nxt = count_r - 1'b1;
                if (req_r == REQ_POP_FRONT) begin
                  rd_addr   = front_r;
                  front_nxt = front_next;
                end else begin
                  rd_addr  = back_prev;
                  back_nxt = back_prev;
                end
              end
            end
            REQ_SEARCH: begin
              if (empty) begin
                state_nxt  = S_IDLE;
                load_out   = 1'b1;
                res_status = ST_NOT_FOUND;
              end else begin
                // first candidate is the entry after the front one
                adv_in    = front_r;
                srch_nxt  = adv_out;
                rd_addr   = adv_out;
                state_nxt = S_SEARCH;
              end
            end
            REQ_REWIND: begin
              if (empty) begin
                state_nxt  = S_IDLE;
                load_out   = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                cursor_nxt = front_r;
                rd_addr    = front_r;
                state_nxt  = S_READ;
              end
            end
            REQ_STEP: begin
              if (empty) begin
                state_nxt  = S_IDLE;
                load_out   = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                adv_in     = cursor_r;
                cursor_nxt = adv_out;
                rd_addr    = adv_out;
                state_nxt  = S_READ;
              end
            end
            default: begin
              state_nxt = S_IDLE;
              load_out  = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        load_out  = 1'b1;
        res_data  = rd_word;
        state_nxt = S_IDLE;
      end
      S_SEARCH: begin
        if (rd_data_r == val_w) begin
          cursor_nxt = srch_r;
          res_data   = val_echo;
          load_out   = 1'b1;
          state_nxt  = S_IDLE;
        end else if (srch_r == front_r) begin
          // front entry is checked last
          cursor_nxt = front_r;
          res_status = ST_NOT_FOUND;
          load_out   = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          adv_in   = srch_r;
          srch_nxt = adv_out;
          rd_addr  = adv_out;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_nxt = out_r;
    if (load_out) begin
      out_nxt.data_out   = res_data;
      out_nxt.status     = res_status;
      out_nxt.item_count = cnt_ext[4:0];
    end
    out_valid_nxt = load_out || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      back_r      <= '0;
      cursor_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      cursor_r    <= cursor_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= req_t'(in_data.req_type);
      val_r <= in_data.element_value;
    end
    srch_r <= srch_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= val_w;
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above capacity");

  a_ring_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == FULL_CNT) |-> (front_r == back_r))
    else $error("front and back disagree with empty or full count");

  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ || state_r == S_SEARCH) |-> !out_valid_r)
    else $error("result register busy while a read result lands");

  a_take_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_EXEC))
    else $error("accepted request not executed");
`endif

endmodule
`default_nettype wire
